[hdl/tnc_pkg.sv]
// Shared constants, codes and direction tables for the torus neighbor copy block.
package tnc_pkg;

  // Fixed field widths of the transaction ports
  localparam int REQ_W       = 2;
  localparam int IDX_W       = 12;
  localparam int DIR_W       = 3;
  localparam int WCOLOR_W    = 8;
  localparam int OCOLOR_W    = 8;
  localparam int SIDE_W      = 7;

  // Parameter defaults
  localparam int MAX_SIDE_DEF   = 64;
  localparam int COLOR_BITS_DEF = 8;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd30;
  localparam int                SIDE_MIN   = 3;

  // Request codes; the unused code behaves as a read
  localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STEP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOR = 1'b1;

  // Coordinate move for one axis
  typedef enum logic [1:0] {
    SH_DEC  = 2'd0,
    SH_KEEP = 2'd1,
    SH_INC  = 2'd2
  } shift_t;

  // Directions run counterclockwise from up-left; up is row-1, left is column-1
  function automatic shift_t dir_row_shift(input logic [DIR_W-1:0] dir);
    shift_t s;
    unique case (dir)
      3'd0, 3'd6, 3'd7: s = SH_DEC;
      3'd1, 3'd5:       s = SH_KEEP;
      default:          s = SH_INC;
    endcase
    return s;
  endfunction

  function automatic shift_t dir_col_shift(input logic [DIR_W-1:0] dir);
    shift_t s;
    unique case (dir)
      3'd0, 3'd1, 3'd2: s = SH_DEC;
      3'd3, 3'd7:       s = SH_KEEP;
      default:          s = SH_INC;
    endcase
    return s;
  endfunction

endpackage

[hdl/tnc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/torus_neighbor_copy_step.sv]
// Top level: torus grid of cell colors with load, read and neighbor-copy step requests.
// States: idle, check, then finish (load, out-of-range), read then finish (read), or
// divider, address, source then finish (step); finish loads the output register.
// Throughput: one transaction at a time; the next is taken once its result has
// entered the output register. Step time is set by the bit-serial row/column divider.
// Reset (synchronous, rst_n low) idles the controller, empties the output register and
// sets grid_side to 30; grid memory is not cleared and must be loaded before use.
module torus_neighbor_copy_step #(
  parameter int MAX_SIDE   = tnc_pkg::MAX_SIDE_DEF,
  parameter int COLOR_BITS = tnc_pkg::COLOR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tnc_pkg::SIDE_W-1:0]    cfg_grid_side,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tnc_pkg::REQ_W-1:0]     in_req_type,
  input  logic [tnc_pkg::IDX_W-1:0]     in_cell_index,
  input  logic [tnc_pkg::DIR_W-1:0]     in_direction,
  input  logic [tnc_pkg::WCOLOR_W-1:0]  in_write_color,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tnc_pkg::OCOLOR_W-1:0]  out_cell_color,
  output logic                          out_status
);

  import tnc_pkg::*;

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_SIDE + 1);          // side value width
  localparam int CW    = $clog2(MAX_SIDE);              // row / column width
  localparam int KW    = (CW > 1) ? $clog2(CW) : 1;     // divider step counter
  localparam int CMPW  = (SW > SIDE_W) ? SW : SIDE_W;
  localparam int TW    = (2 * SW > IDX_W) ? 2 * SW : IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ADDR,
    ST_SRC,
    ST_RD,
    ST_FIN
  } state_t;

  state_t                  state_r;
  logic [SIDE_W-1:0]       grid_side_r;
  logic [SW-1:0]           n_r;
  logic [REQ_W-1:0]        req_r;
  logic [IDX_W-1:0]        idx_r;
  logic [DIR_W-1:0]        dir_r;
  logic [COLOR_BITS-1:0]   wcolor_r;
  logic [TW-1:0]           rem_r;
  logic [CW-1:0]           q_r;
  logic [KW-1:0]           k_r;
  logic [COLOR_BITS-1:0]   res_color_r;
  logic                    res_status_r;
  logic                    out_valid_r;
  logic [OCOLOR_W-1:0]     out_color_r;
  logic                    out_status_r;

  logic                    in_acc;
  logic                    out_free;
  logic [SW-1:0]           n_sat;
  logic [CMPW-1:0]         side_ext;
  logic                    idx_in_range;
  logic [TW-1:0]           div_trial;
  logic                    div_take;
  logic [CW-1:0]           n_m1;
  logic [CW-1:0]           nbr_row;
  logic [CW-1:0]           nbr_col;
  logic [AW-1:0]           src_addr;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [COLOR_BITS-1:0]   mem_wdata;
  logic                    mem_re;
  logic [AW-1:0]           mem_raddr;
  logic [COLOR_BITS-1:0]   mem_rdata;

  // Wrap one coordinate around the torus
  function automatic logic [CW-1:0] wrap_coord(input logic [CW-1:0] c,
                                               input logic [CW-1:0] last,
                                               input shift_t        s);
    logic [CW-1:0] r;
    unique case (s)
      SH_DEC:  r = (c == '0)   ? last : CW'(c - CW'(1));
      SH_INC:  r = (c == last) ? '0   : CW'(c + CW'(1));
      default: r = c;
    endcase
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_cell_color = out_color_r;
  assign out_status     = out_status_r;

  // Side in use: grid_side saturated to SIDE_MIN..MAX_SIDE
  always_comb begin
    side_ext = CMPW'(grid_side_r);
    priority if (side_ext < CMPW'(SIDE_MIN)) begin
      n_sat = SW'(SIDE_MIN);
    end else if (side_ext > CMPW'(MAX_SIDE)) begin
      n_sat = SW'(MAX_SIDE);
    end else begin
      n_sat = SW'(side_ext);
    end
  end

  assign idx_in_range = TW'(idx_r) < (TW'(n_r) * TW'(n_r));

  // Restoring divider, one quotient bit per cycle, MSB first
  assign div_trial = TW'(n_r) << k_r;
  assign div_take  = rem_r >= div_trial;

  // Neighbor address from quotient (row) and remainder (column)
  assign n_m1    = CW'(n_r - SW'(1));
  assign nbr_row = wrap_coord(q_r, n_m1, dir_row_shift(dir_r));
  assign nbr_col = wrap_coord(CW'(rem_r), n_m1, dir_col_shift(dir_r));
  assign src_addr = AW'(TW'(nbr_row) * TW'(n_r) + TW'(nbr_col));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(idx_r);
    mem_wdata = wcolor_r;
    mem_re    = 1'b0;
    mem_raddr = AW'(idx_r);
    unique case (state_r)
      ST_CHECK: begin
        if (idx_in_range && req_r == REQ_LOAD) begin
          mem_we = 1'b1;
        end else if (idx_in_range && req_r != REQ_STEP) begin
          mem_re = 1'b1;
        end
      end
      ST_ADDR: begin
        mem_re    = 1'b1;
        mem_raddr = src_addr;
      end
      ST_SRC: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      grid_side_r <= SIDE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        grid_side_r <= cfg_grid_side;
      end
      // the finish state reloads the output register itself
      if (out_valid_r && !out_stall && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            req_r    <= in_req_type;
            idx_r    <= in_cell_index;
            dir_r    <= in_direction;
            wcolor_r <= COLOR_BITS'(in_write_color);
            n_r      <= n_sat;
            state_r  <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!idx_in_range) begin
            res_color_r  <= '0;
            res_status_r <= STATUS_OOR;
            state_r      <= ST_FIN;
          end else if (req_r == REQ_LOAD) begin
            res_color_r  <= wcolor_r;
            res_status_r <= STATUS_OK;
            state_r      <= ST_FIN;
          end else if (req_r == REQ_STEP) begin
            rem_r   <= TW'(idx_r);
            q_r     <= '0;
            k_r     <= KW'(CW - 1);
            state_r <= ST_DIV;
          end else begin
            state_r <= ST_RD;
          end
        end
        ST_DIV: begin
          if (div_take) begin
            rem_r    <= rem_r - div_trial;
            q_r[k_r] <= 1'b1;
          end
          if (k_r == '0) begin
            state_r <= ST_ADDR;
          end else begin
            k_r <= k_r - KW'(1);
          end
        end
        ST_ADDR: begin
          state_r <= ST_SRC;
        end
        ST_SRC: begin
          res_color_r  <= mem_rdata;
          res_status_r <= STATUS_OK;
          state_r      <= ST_FIN;
        end
        ST_RD: begin
          res_color_r  <= mem_rdata;
          res_status_r <= STATUS_OK;
          state_r      <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_color_r  <= OCOLOR_W'(res_color_r);
            out_status_r <= res_status_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  tnc_ram #(
    .WIDTH (COLOR_BITS),
    .DEPTH (DEPTH)
  ) u_grid_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

`ifndef ASSERT_OFF
  // Divider result must reconstruct the index with a remainder below the side
  a_div_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADDR) |->
      ((rem_r < TW'(n_r)) && (TW'(q_r) * TW'(n_r) + rem_r == TW'(idx_r))))
    else $error("divider produced wrong row/column");

  // Grid is never written for an index outside the grid in use
  a_we_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> idx_in_range)
    else $error("grid write outside grid in use");

  // Out-of-range transactions report color zero
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_OOR) |-> (out_cell_color == '0))
    else $error("out-of-range result with nonzero color");

  // A new result only appears from the finish state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == ST_FIN))
    else $error("result loaded outside finish state");

  // Accepting a transaction blocks further input on the next cycle
  a_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input not stalled after accept");
`endif

endmodule
